// ===== sv/pixel_work_dispatcher_top_assert.svh =====
// ============================================================================
// pixel_work_dispatcher_top_assert.svh
// Assertion macros for the pixel work dispatcher. They expand to concurrent
// assertions on i_clk, disabled while i_rst_n is low, and to nothing when
// SYNTHESIS is defined.
// ============================================================================
`ifndef PIXEL_WORK_DISPATCHER_TOP_ASSERT_SVH
`define PIXEL_WORK_DISPATCHER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge.
`define PWD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// Check that a condition in one cycle leads to another in the next cycle.
`define PWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define PWD_ASSERT(label, prop, msg)
`define PWD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/pwd_pkg.sv =====
// ============================================================================
// pwd_pkg
// Shared types, codes and defaults of the pixel work dispatcher.
// ============================================================================
package pwd_pkg;

    // Defaults for the top level parameters
    localparam int MAX_WORKERS_DEF = 8;
    localparam int PIXEL_DEPTH_DEF = 16;
    localparam int DEFAULT_LIMIT   = 10;

    // Pixel payload: x, y and color packed into one store entry
    localparam int PIXEL_W = 56;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_ID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_ID       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_IDS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT = 3'd4;

    // Incoming packet opcodes
    localparam logic [2:0] IN_OP_READ_RDY   = 3'd0;
    localparam logic [2:0] IN_OP_PIXEL      = 3'd1;
    localparam logic [2:0] IN_OP_FINISHED   = 3'd2;
    localparam logic [2:0] IN_OP_END        = 3'd3;
    localparam logic [2:0] IN_OP_WRITE_DONE = 3'd4;

    // Item modes
    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_PACKET = 1'b1;

    // Outgoing packet opcodes
    localparam logic [1:0] OUT_READ_REQ  = 2'd0;
    localparam logic [1:0] OUT_NEXT_REQ  = 2'd1;
    localparam logic [1:0] OUT_EXECUTE   = 2'd2;
    localparam logic [1:0] OUT_WRITE_REQ = 2'd3;

    // Classified commands handed from front to back
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RDRDY  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PIXEL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FINISH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_END    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WRDONE = 3'd5;

    // Gateway phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_WAIT_RR = 2'd1;
    localparam logic [1:0] PH_PROC    = 2'd2;
    localparam logic [1:0] PH_WAIT_WD = 2'd3;

    typedef struct packed {
        logic [7:0]  gateway_id;
        logic [7:0]  ram_id;
        logic [3:0]  worker_count;
        logic [63:0] worker_ids;
        logic [4:0]  buffer_limit;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0] code;
        logic [7:0]       sender;
        logic [15:0]      xpos;
        logic [15:0]      ypos;
        logic [23:0]      color;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  sender;
        logic [7:0]  receiver;
        logic [15:0] xpos;
        logic [15:0] ypos;
        logic [23:0] color;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [1:0] phase;
        logic       fill_nz;
        logic       in_disp;
        logic       busy_any;
    } t_bstat;

endpackage

// ===== sv/pwd_ram.sv =====
// ============================================================================
// pwd_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module pwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read; read data is registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pwd_front.sv =====
// ============================================================================
// pwd_front
// Input stage: accepts items, classifies them into commands and drops
// packets that can never have an effect.
// ============================================================================
module pwd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_ram_id,
    input  logic          push,
    output logic          full,
    input  logic          i_mode,
    input  logic [2:0]    i_in_opcode,
    input  logic [7:0]    i_in_sender,
    input  logic [15:0]   i_in_xpos,
    input  logic [15:0]   i_in_ypos,
    input  logic [23:0]   i_in_color,
    output logic          o_cmd_valid,
    output pwd_pkg::t_cmd o_cmd,
    input  logic          i_q_ready
);

    import pwd_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic keep;
    logic from_ram;
    logic accept;

    assign from_ram = (i_in_sender == i_ram_id);
    assign full     = r_valid && !i_q_ready;
    assign accept   = push && !full;

    // Classify the item; packets that match no command are dropped here
    always_comb begin
        n_cmd.sender = i_in_sender;
        n_cmd.xpos   = i_in_xpos;
        n_cmd.ypos   = i_in_ypos;
        n_cmd.color  = i_in_color;
        n_cmd.code   = CMD_START;
        keep         = 1'b0;
        if (i_mode == MODE_START) begin
            keep = 1'b1;
        end else begin
            unique case (i_in_opcode)
                IN_OP_READ_RDY: begin
                    n_cmd.code = CMD_RDRDY;
                    keep       = from_ram;
                end
                IN_OP_PIXEL: begin
                    n_cmd.code = CMD_PIXEL;
                    keep       = from_ram;
                end
                IN_OP_FINISHED: begin
                    n_cmd.code = CMD_FINISH;
                    keep       = 1'b1;
                end
                IN_OP_END: begin
                    n_cmd.code = CMD_END;
                    keep       = from_ram;
                end
                IN_OP_WRITE_DONE: begin
                    n_cmd.code = CMD_WRDONE;
                    keep       = from_ram;
                end
                default: begin
                    keep = 1'b0;
                end
            endcase
        end
    end

    // Hold the classified command until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_q_ready) begin
            r_valid <= accept && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

// ===== sv/pwd_cmdq.sv =====
// ============================================================================
// pwd_cmdq
// Short command queue that decouples the front stage from the back sequencer.
// ============================================================================
module pwd_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pwd_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output pwd_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    import pwd_pkg::*;

    localparam int AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cmd          r_slot [CMDQ_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_count != CW'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(CMDQ_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== sv/pwd_back.sv =====
// ============================================================================
// pwd_back
// Back sequencer: owns the phase, the pixel FIFO and the worker busy bits,
// executes commands and emits outgoing packets, at most one per cycle, holding while the result is not popped.
// ============================================================================
module pwd_back #(
    parameter int MAX_WORKERS = 8,
    parameter int PIXEL_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pwd_pkg::t_cfg   i_cfg,
    input  logic            i_cmd_valid,
    input  pwd_pkg::t_cmd   i_cmd,
    output logic            o_cmd_pop,
    output logic            o_res_valid,
    output pwd_pkg::t_res   o_res,
    input  logic            i_res_pop,
    output pwd_pkg::t_bstat o_stat
);

    import pwd_pkg::*;

    localparam int FILL_W = $clog2(PIXEL_DEPTH + 1);
    localparam int PTR_W  = $clog2(PIXEL_DEPTH);
    localparam int CMP_W  = (FILL_W > 5) ? FILL_W : 5;
    localparam int WI_W   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_REQ  = 2'd1;
    localparam logic [1:0] S_DISP = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [1:0]             r_phase, n_phase;
    logic [PTR_W-1:0]       r_rp, n_rp;
    logic [PTR_W-1:0]       r_wp, n_wp;
    logic [FILL_W-1:0]      r_fill, n_fill;
    logic [MAX_WORKERS-1:0] r_busy, n_busy;
    logic                   r_res_valid, n_res_valid;
    t_res                   r_res, n_res;

    logic                   out_ready;
    logic                   emit;
    logic                   ram_we;
    logic [PIXEL_W-1:0]     ram_rdata;
    logic [CMP_W-1:0]       lim_raw;
    logic [CMP_W-1:0]       eff_lim;
    logic [3:0]             eff_cnt;
    logic [MAX_WORKERS-1:0] in_use;
    logic [MAX_WORKERS-1:0] idle;
    logic [MAX_WORKERS-1:0] idle2;
    logic                   first_any;
    logic [WI_W-1:0]        first_idx;
    logic                   fill_nz;
    logic                   room;
    logic                   more;
    logic                   disp_last;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(PIXEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Effective buffer limit and worker count
    always_comb begin
        lim_raw = (i_cfg.buffer_limit == '0) ? CMP_W'(DEFAULT_LIMIT)
                                             : CMP_W'(i_cfg.buffer_limit);
        eff_lim = (lim_raw > CMP_W'(PIXEL_DEPTH)) ? CMP_W'(PIXEL_DEPTH) : lim_raw;
        eff_cnt = (i_cfg.worker_count > 4'(MAX_WORKERS)) ? 4'(MAX_WORKERS)
                                                         : i_cfg.worker_count;
        for (int i = 0; i < MAX_WORKERS; i++) begin
            in_use[i] = (4'(i) < eff_cnt);
        end
    end

    // Pick the first idle worker and look ahead for a second one
    always_comb begin
        idle      = in_use & ~r_busy;
        first_any = 1'b0;
        first_idx = '0;
        for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
            if (idle[i]) begin
                first_any = 1'b1;
                first_idx = WI_W'(i);
            end
        end
        idle2 = idle & ~(MAX_WORKERS'(1) << first_idx);
    end

    assign out_ready = !r_res_valid || i_res_pop;
    assign fill_nz   = (r_fill != '0);
    assign room      = (CMP_W'(r_fill) < eff_lim);
    assign more      = fill_nz && first_any;
    assign disp_last = !((r_fill > FILL_W'(1)) && (idle2 != '0));

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_busy      = r_busy;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        emit        = 1'b0;
        n_res       = r_res;
        n_res.sender   = i_cfg.gateway_id;
        n_res.receiver = i_cfg.ram_id;
        n_res.xpos     = '0;
        n_res.ypos     = '0;
        n_res.color    = '0;
        n_res.last     = 1'b1;
        n_res.opcode   = OUT_NEXT_REQ;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_ready) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.code)
                        CMD_START: begin
                            if (r_phase == PH_IDLE) begin
                                emit         = 1'b1;
                                n_res.opcode = OUT_READ_REQ;
                                n_phase      = PH_WAIT_RR;
                            end
                        end
                        CMD_RDRDY: begin
                            if (r_phase == PH_WAIT_RR) begin
                                emit         = 1'b1;
                                n_res.opcode = OUT_NEXT_REQ;
                                n_phase      = PH_PROC;
                            end
                        end
                        CMD_PIXEL: begin
                            if (r_phase == PH_PROC) begin
                                if (room) begin
                                    ram_we = 1'b1;
                                    n_wp   = ptr_inc(r_wp);
                                    n_fill = r_fill + FILL_W'(1);
                                end
                                n_state = S_REQ;
                            end
                        end
                        CMD_FINISH: begin
                            if (r_phase == PH_PROC) begin
                                for (int i = 0; i < MAX_WORKERS; i++) begin
                                    if (in_use[i] &&
                                        i_cfg.worker_ids[8*i +: 8] == i_cmd.sender) begin
                                        n_busy[i] = 1'b0;
                                    end
                                end
                                n_state = S_REQ;
                            end
                        end
                        CMD_END: begin
                            if (r_phase == PH_PROC && !fill_nz && r_busy == '0) begin
                                emit         = 1'b1;
                                n_res.opcode = OUT_WRITE_REQ;
                                n_phase      = PH_WAIT_WD;
                            end
                        end
                        CMD_WRDONE: begin
                            if (r_phase == PH_WAIT_WD) begin
                                n_phase = PH_IDLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_REQ: begin
                // Ask memory for the next pixel while the FIFO has room
                if (room) begin
                    if (out_ready) begin
                        emit         = 1'b1;
                        n_res.opcode = OUT_NEXT_REQ;
                        n_res.last   = !more;
                        n_state      = more ? S_DISP : S_IDLE;
                    end
                end else begin
                    n_state = more ? S_DISP : S_IDLE;
                end
            end
            S_DISP: begin
                // Hand the oldest buffered pixel to the first idle worker
                if (out_ready) begin
                    emit              = 1'b1;
                    n_res.opcode      = OUT_EXECUTE;
                    n_res.receiver    = i_cfg.worker_ids[8*first_idx +: 8];
                    n_res.xpos        = ram_rdata[55:40];
                    n_res.ypos        = ram_rdata[39:24];
                    n_res.color       = ram_rdata[23:0];
                    n_res.last        = disp_last;
                    n_busy[first_idx] = 1'b1;
                    n_rp              = ptr_inc(r_rp);
                    n_fill            = r_fill - FILL_W'(1);
                    n_state           = disp_last ? S_IDLE : S_DISP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (emit) begin
            n_res_valid = 1'b1;
        end else if (i_res_pop) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_busy      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_busy      <= n_busy;
            r_res_valid <= n_res_valid;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= n_res;
        end
    end

    // Pixel FIFO storage; read address follows the next read pointer
    pwd_ram #(
        .WIDTH(PIXEL_W),
        .DEPTH(PIXEL_DEPTH)
    ) u_pixel_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wp),
        .i_wdata({i_cmd.xpos, i_cmd.ypos, i_cmd.color}),
        .i_raddr(n_rp),
        .o_rdata(ram_rdata)
    );

    assign o_res_valid     = r_res_valid;
    assign o_res           = r_res;
    assign o_stat.phase    = r_phase;
    assign o_stat.fill_nz  = fill_nz;
    assign o_stat.in_disp  = (r_state == S_DISP);
    assign o_stat.busy_any = (r_busy != '0);

endmodule

// ===== sv/pixel_work_dispatcher_top.sv =====
// ============================================================================
// pixel_work_dispatcher_top
// Packet gateway that fetches pixels from a memory node, buffers them and
// hands them to idle worker nodes.
// Input queue side: push/full with mode and packet fields; a beat is taken
// when push is high and full is low. Result queue side: empty/pop; the
// oldest outgoing packet is shown while empty is low, last marks the final
// packet caused by one input. Registers are written through the cfg channel
// (index, data, valid/ready; ready is always high); the user must write them
// only while the block is idle, as the block itself does not enforce it. A
// beat passes the front register, the command queue and the result register
// of the back sequencer. A pixel or finished notice is executed in the idle
// state and passes the next-pixel request step; buffered pixels are then
// dispatched one per cycle while results are popped, using the registered
// read of the pixel RAM. The sequencer takes the next command only once it
// is back in idle. Reset clears the phase to idle, the FIFO and all busy bits
// and loads the register defaults. While the receiver stalls, the result
// register holds and the command queue and front register fill up to three.
// ============================================================================
`include "pixel_work_dispatcher_top_assert.svh"

module pixel_work_dispatcher_top #(
    parameter int MAX_WORKERS = pwd_pkg::MAX_WORKERS_DEF,
    parameter int PIXEL_DEPTH = pwd_pkg::PIXEL_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pwd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]                    i_cfg_data,
    // Input items
    input  logic                           push,
    output logic                           full,
    input  logic                           i_mode,
    input  logic [2:0]                     i_in_opcode,
    input  logic [7:0]                     i_in_sender,
    input  logic [15:0]                    i_in_xpos,
    input  logic [15:0]                    i_in_ypos,
    input  logic [23:0]                    i_in_color,
    // Result items
    output logic                           empty,
    input  logic                           pop,
    output logic [1:0]                     o_out_opcode,
    output logic [7:0]                     o_out_sender,
    output logic [7:0]                     o_out_receiver,
    output logic [15:0]                    o_out_xpos,
    output logic [15:0]                    o_out_ypos,
    output logic [23:0]                    o_out_color,
    output logic                           o_last
);

    import pwd_pkg::*;

    t_cfg   r_cfg;
    logic   f_valid;
    t_cmd   f_cmd;
    logic   q_ready;
    logic   q_valid;
    t_cmd   q_cmd;
    logic   q_pop;
    logic   res_valid;
    t_res   res;
    t_bstat st;

    // Register writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gateway_id   <= '0;
            r_cfg.ram_id       <= '0;
            r_cfg.worker_count <= 4'd1;
            r_cfg.worker_ids   <= '0;
            r_cfg.buffer_limit <= 5'(DEFAULT_LIMIT);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GATEWAY_ID:   r_cfg.gateway_id   <= i_cfg_data[7:0];
                CFG_RAM_ID:       r_cfg.ram_id       <= i_cfg_data[7:0];
                CFG_WORKER_COUNT: r_cfg.worker_count <= i_cfg_data[3:0];
                CFG_WORKER_IDS:   r_cfg.worker_ids   <= i_cfg_data;
                CFG_BUFFER_LIMIT: r_cfg.buffer_limit <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    pwd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ram_id   (r_cfg.ram_id),
        .push       (push),
        .full       (full),
        .i_mode     (i_mode),
        .i_in_opcode(i_in_opcode),
        .i_in_sender(i_in_sender),
        .i_in_xpos  (i_in_xpos),
        .i_in_ypos  (i_in_ypos),
        .i_in_color (i_in_color),
        .o_cmd_valid(f_valid),
        .o_cmd      (f_cmd),
        .i_q_ready  (q_ready)
    );

    pwd_cmdq u_cmdq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_valid),
        .i_cmd  (f_cmd),
        .o_ready(q_ready),
        .o_valid(q_valid),
        .o_cmd  (q_cmd),
        .i_pop  (q_pop)
    );

    pwd_back #(
        .MAX_WORKERS(MAX_WORKERS),
        .PIXEL_DEPTH(PIXEL_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_valid(q_valid),
        .i_cmd      (q_cmd),
        .o_cmd_pop  (q_pop),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_res_pop  (pop),
        .o_stat     (st)
    );

    assign empty          = !res_valid;
    assign o_out_opcode   = res.opcode;
    assign o_out_sender   = res.sender;
    assign o_out_receiver = res.receiver;
    assign o_out_xpos     = res.xpos;
    assign o_out_ypos     = res.ypos;
    assign o_out_color    = res.color;
    assign o_last         = res.last;

    // Write wait needs an empty FIFO and no busy worker
    `PWD_ASSERT(a_wait_wd_clean, st.phase != PH_WAIT_WD || (!st.fill_nz && !st.busy_any), "write wait with pixels or busy workers")
    // Buffered pixels exist only while processing
    `PWD_ASSERT(a_fill_in_proc, !st.fill_nz || st.phase == PH_PROC, "pixels buffered outside processing")
    // Dispatch runs only with a buffered pixel
    `PWD_ASSERT(a_disp_has_pixel, !st.in_disp || st.fill_nz, "dispatch with empty pixel FIFO")
    // Write wait leaves only for idle
    `PWD_ASSERT_NEXT(a_wait_wd_exit, st.phase == PH_WAIT_WD, st.phase == PH_WAIT_WD || st.phase == PH_IDLE, "bad phase after write wait")

endmodule
